>>> sv/spq_pkg.sv
// Package for the sorted priority queue.
// Holds the entry layout, the action and status codes and the control states.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 5;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_DEQ
    } state_t;

endpackage

`default_nettype wire

>>> sv/spq_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
// Used for the entry store of the sorted priority queue. No dependencies.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Sorted priority queue: entries live in a circular RAM kept in priority order.
// Dequeue reads the head, then loads the result; full or empty refusals are answered from idle.
// Enqueue into an empty queue writes the head slot directly; otherwise each stored entry
// with a higher priority value is shifted up one slot, one per cycle, by the
// read-compare-write loop on the RAM port. One word is in flight at a time.
// Synchronous active-low reset empties the queue; the RAM itself is not cleared.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_action,
    input  wire logic signed [spq_pkg::DATA_W-1:0]  s_data_value,
    input  wire logic        [spq_pkg::PRIO_W-1:0]  s_prio,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic             [1:0]                  m_status,
    output logic signed      [spq_pkg::DATA_W-1:0]  m_out_data,
    output logic             [spq_pkg::PRIO_W-1:0]  m_out_prio,
    output logic             [spq_pkg::OCC_W-1:0]   m_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] left_reg, left_next;
    spq_pkg::entry_t new_reg, new_next;

    logic                        m_valid_reg, m_valid_next;
    logic [1:0]                  m_status_reg, m_status_next;
    logic [spq_pkg::DATA_W-1:0]  m_data_reg, m_data_next;
    logic [spq_pkg::PRIO_W-1:0]  m_prio_reg, m_prio_next;
    logic [spq_pkg::OCC_W-1:0]   m_occ_reg, m_occ_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    spq_pkg::entry_t               ram_wdata;
    logic [spq_pkg::ENTRY_W-1:0]   ram_rdata;
    spq_pkg::entry_t               rd_entry;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             shift_up;
    logic             out_load;
    logic [AW:0]      tail_sum;
    logic [AW-1:0]    tail;
    logic [AW-1:0]    tail_prev;
    logic [CW+spq_pkg::OCC_W-1:0] occ_wide;
    spq_pkg::entry_t  in_entry;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = spq_pkg::entry_t'(ram_rdata);
    assign in_entry = '{prio: s_prio, data: s_data_value};

    assign s_ready  = (state_reg == spq_pkg::S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign shift_up = (rd_entry.prio > new_reg.prio);

    assign tail_sum  = {1'b0, head_reg} + {1'b0, count_reg[AW-1:0]};
    assign tail      = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                    : tail_sum[AW-1:0];
    assign tail_prev = ptr_dec(tail);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_action == spq_pkg::ACT_ENQ) begin
                        if (!is_full && !is_empty) begin
                            state_next = spq_pkg::S_SCAN;
                        end
                    end else if (!is_empty) begin
                        state_next = spq_pkg::S_DEQ;
                    end
                end
            end
            spq_pkg::S_SCAN: begin
                if (!shift_up) begin
                    state_next = spq_pkg::S_IDLE;
                end else if (left_reg == '0) begin
                    state_next = spq_pkg::S_INS;
                end
            end
            spq_pkg::S_INS: begin
                state_next = spq_pkg::S_IDLE;
            end
            spq_pkg::S_DEQ: begin
                state_next = spq_pkg::S_IDLE;
            end
            default: begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        left_next     = left_reg;
        new_next      = new_reg;
        ram_we        = 1'b0;
        ram_waddr     = wr_ptr_reg;
        ram_wdata     = new_reg;
        ram_raddr     = tail_prev;
        out_load      = 1'b0;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_prio_next   = m_prio_reg;
        case (state_reg)
            spq_pkg::S_IDLE: begin
                new_next    = in_entry;
                rd_ptr_next = tail_prev;
                wr_ptr_next = tail;
                left_next   = AW'(count_reg - CW'(1));
                if (s_action == spq_pkg::ACT_DEQ) begin
                    ram_raddr = head_reg;
                end
                if (accept) begin
                    if (s_action == spq_pkg::ACT_ENQ) begin
                        if (is_full) begin
                            out_load      = 1'b1;
                            m_status_next = spq_pkg::ST_FULL;
                            m_data_next   = '0;
                            m_prio_next   = '0;
                        end else if (is_empty) begin
                            ram_we        = 1'b1;
                            ram_waddr     = head_reg;
                            ram_wdata     = in_entry;
                            count_next    = count_reg + CW'(1);
                            out_load      = 1'b1;
                            m_status_next = spq_pkg::ST_DONE;
                            m_data_next   = '0;
                            m_prio_next   = '0;
                        end
                    end else if (is_empty) begin
                        out_load      = 1'b1;
                        m_status_next = spq_pkg::ST_EMPTY;
                        m_data_next   = '0;
                        m_prio_next   = '0;
                    end
                end
            end
            spq_pkg::S_SCAN: begin
                ram_we    = 1'b1;
                ram_waddr = wr_ptr_reg;
                ram_raddr = ptr_dec(rd_ptr_reg);
                if (shift_up) begin
                    ram_wdata   = rd_entry;
                    wr_ptr_next = rd_ptr_reg;
                    rd_ptr_next = ptr_dec(rd_ptr_reg);
                    left_next   = left_reg - AW'(1);
                end else begin
                    ram_wdata     = new_reg;
                    count_next    = count_reg + CW'(1);
                    out_load      = 1'b1;
                    m_status_next = spq_pkg::ST_DONE;
                    m_data_next   = '0;
                    m_prio_next   = '0;
                end
            end
            spq_pkg::S_INS: begin
                ram_we        = 1'b1;
                ram_waddr     = wr_ptr_reg;
                ram_wdata     = new_reg;
                count_next    = count_reg + CW'(1);
                out_load      = 1'b1;
                m_status_next = spq_pkg::ST_DONE;
                m_data_next   = '0;
                m_prio_next   = '0;
            end
            spq_pkg::S_DEQ: begin
                head_next     = ptr_inc(head_reg);
                count_next    = count_reg - CW'(1);
                out_load      = 1'b1;
                m_status_next = spq_pkg::ST_DONE;
                m_data_next   = rd_entry.data;
                m_prio_next   = rd_entry.prio;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
        occ_wide     = {{spq_pkg::OCC_W{1'b0}}, count_next};
        m_occ_next   = out_load ? occ_wide[spq_pkg::OCC_W-1:0] : m_occ_reg;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spq_pkg::S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        left_reg     <= left_next;
        new_reg      <= new_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_prio_reg   <= m_prio_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_data  = m_data_reg;
    assign m_out_prio  = m_prio_reg;
    assign m_occupancy = m_occ_reg;

endmodule

`default_nettype wire

>>> sv/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and on the ports of sorted_priority_queue.
`default_nettype none

module spq_checker #(
    parameter int DEPTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [1:0]                  m_status,
    input  wire logic [spq_pkg::DATA_W-1:0]  m_out_data,
    input  wire logic [spq_pkg::PRIO_W-1:0]  m_out_prio,
    input  wire logic [spq_pkg::OCC_W-1:0]   m_occupancy
);

    localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = spq_pkg::OCC_W'(DEPTH);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_data)
            && $stable(m_out_prio) && $stable(m_occupancy))
        else $error("result word changed while stalled");

    // Only a completed dequeue carries data and priority.
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != spq_pkg::ST_DONE) |-> (m_out_data == '0) && (m_out_prio == '0))
        else $error("refused word carries a payload");

    // A refused dequeue reports an empty queue.
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == spq_pkg::ST_EMPTY) |-> (m_occupancy == '0))
        else $error("empty status with nonzero occupancy");

    // A refused enqueue reports a full queue.
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == spq_pkg::ST_FULL) |-> (m_occupancy == FULL_OCC))
        else $error("full status with wrong occupancy");

    // The status code is always one of the three defined ones.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == spq_pkg::ST_DONE) || (m_status == spq_pkg::ST_EMPTY)
            || (m_status == spq_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_out_data  (m_out_data),
    .m_out_prio  (m_out_prio),
    .m_occupancy (m_occupancy)
);

`default_nettype wire

>>> verif/tb_sorted_priority_queue.sv
// Self-checking testbench for sorted_priority_queue: random and directed insert and
// remove words, checked against a sorted-list predictor kept inside this file.
// Depends on spq_pkg and the sorted_priority_queue RTL.

module tb_sorted_priority_queue;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_WORDS = 400;

    typedef struct {
        spq_pkg::action_t           action;
        logic [spq_pkg::DATA_W-1:0] data;
        logic [spq_pkg::PRIO_W-1:0] prio;
        bit                         hold_until_drained;
    } queue_word_t;

    typedef struct packed {
        spq_pkg::status_t           status;
        logic [spq_pkg::DATA_W-1:0] data;
        logic [spq_pkg::PRIO_W-1:0] prio;
        logic [spq_pkg::OCC_W-1:0]  occupancy;
    } queue_result_t;

    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic                              s_action     = 1'b0;
    logic signed [spq_pkg::DATA_W-1:0] s_data_value = '0;
    logic        [spq_pkg::PRIO_W-1:0] s_prio       = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic        [1:0]                 m_status;
    logic signed [spq_pkg::DATA_W-1:0] m_out_data;
    logic        [spq_pkg::PRIO_W-1:0] m_out_prio;
    logic        [spq_pkg::OCC_W-1:0]  m_occupancy;

    queue_word_t      pending_words[$];
    queue_word_t      live_word;
    spq_pkg::entry_t  held_entries[$];
    queue_result_t    results_due[$];

    int total_words     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int n_inserted      = 0;
    int n_removed       = 0;
    int n_full          = 0;
    int n_empty         = 0;

    sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_value(s_data_value),
        .s_prio      (s_prio),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_data  (m_out_data),
        .m_out_prio  (m_out_prio),
        .m_occupancy (m_occupancy)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_pct(bit sender, int done_count);
        if (done_count * 3 < total_words) begin
            return sender ? 19 : 59;
        end else if (done_count * 3 < total_words * 2) begin
            return sender ? 59 : 19;
        end
        return 0;
    endfunction

    function automatic void add_word(spq_pkg::action_t action,
                                     logic [spq_pkg::DATA_W-1:0] data,
                                     logic [spq_pkg::PRIO_W-1:0] prio, bit hold);
        queue_word_t w;
        w.action             = action;
        w.data               = data;
        w.prio               = prio;
        w.hold_until_drained = hold;
        pending_words.push_back(w);
    endfunction

    function automatic void predict_sorted_queue(queue_word_t w);
        queue_result_t   r;
        spq_pkg::entry_t e;
        int              slot;
        r.status    = spq_pkg::ST_DONE;
        r.data      = '0;
        r.prio      = '0;
        r.occupancy = '0;
        if (w.action == spq_pkg::ACT_ENQ) begin
            if (held_entries.size() >= QUEUE_DEPTH) begin
                r.status = spq_pkg::ST_FULL;
                n_full++;
            end else begin
                slot = 0;
                while (slot < held_entries.size() && held_entries[slot].prio <= w.prio) begin
                    slot++;
                end
                e.prio = w.prio;
                e.data = w.data;
                held_entries.insert(slot, e);
                n_inserted++;
            end
        end else begin
            if (held_entries.size() == 0) begin
                r.status = spq_pkg::ST_EMPTY;
                n_empty++;
            end else begin
                e      = held_entries.pop_front();
                r.data = e.data;
                r.prio = e.prio;
                n_removed++;
            end
        end
        r.occupancy = spq_pkg::OCC_W'(held_entries.size());
        results_due.push_back(r);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        bit load;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_sorted_queue(live_word);
                words_sent++;
            end
            load = 1'b0;
            if ((!s_valid || s_ready) && pending_words.size() != 0) begin
                load = $urandom_range(99) >= idle_pct(1'b1, words_sent);
                if (pending_words[0].hold_until_drained && results_due.size() != 0) begin
                    load = 1'b0;
                end
            end
            if (load) begin
                live_word = pending_words.pop_front();
                s_action     <= live_word.action;
                s_data_value <= live_word.data;
                s_prio       <= live_word.prio;
            end
            if (!s_valid || s_ready) begin
                s_valid <= load;
            end
        end
    end

    always @(posedge aclk) begin
        queue_result_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result word arrived with nothing outstanding");
                end else begin
                    due = results_due.pop_front();
                    if (m_status !== due.status) begin
                        report_mismatch($sformatf("word %0d status got %0d, wanted %0d",
                            results_checked, m_status, due.status));
                    end
                    if (m_out_data !== due.data) begin
                        report_mismatch($sformatf("word %0d data got %h, wanted %h",
                            results_checked, m_out_data, due.data));
                    end
                    if (m_out_prio !== due.prio) begin
                        report_mismatch($sformatf("word %0d priority got %h, wanted %h",
                            results_checked, m_out_prio, due.prio));
                    end
                    if (m_occupancy !== due.occupancy) begin
                        report_mismatch($sformatf("word %0d occupancy got %0d, wanted %0d",
                            results_checked, m_occupancy, due.occupancy));
                    end
                end
                results_checked++;
            end
            m_ready <= $urandom_range(99) >= idle_pct(1'b0, results_checked);
        end
    end

    initial begin
        int                         n;
        int                         i;
        int                         burst_len;
        int                         enq_bias;
        bit                         is_enq;
        logic [spq_pkg::PRIO_W-1:0] prio;

        add_word(spq_pkg::ACT_DEQ, 32'h5A5A_A5A5, 16'hFFFF, 1'b0);
        add_word(spq_pkg::ACT_ENQ, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        add_word(spq_pkg::ACT_ENQ, 32'h8000_0000, 16'h0000, 1'b0);
        add_word(spq_pkg::ACT_ENQ, 32'h0000_0001, 16'h0005, 1'b0);
        add_word(spq_pkg::ACT_ENQ, 32'h0000_0002, 16'h0005, 1'b0);
        add_word(spq_pkg::ACT_ENQ, 32'h0000_0003, 16'h0005, 1'b0);
        add_word(spq_pkg::ACT_ENQ, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        for (i = 0; i < 10; i++) begin
            add_word(spq_pkg::ACT_ENQ, $urandom, 16'($urandom_range(6)), 1'b0);
        end
        add_word(spq_pkg::ACT_ENQ, 32'h1234_5678, 16'h0001, 1'b0);
        add_word(spq_pkg::ACT_DEQ, $urandom, 16'($urandom), 1'b1);
        for (i = 0; i < 6; i++) begin
            add_word(spq_pkg::ACT_DEQ, $urandom, 16'($urandom), 1'b0);
        end

        n = 0;
        while (n < RANDOM_WORDS) begin
            burst_len = $urandom_range(40, 8);
            case ($urandom_range(2))
                0:       enq_bias = 80;
                1:       enq_bias = 20;
                default: enq_bias = 50;
            endcase
            for (i = 0; i < burst_len && n < RANDOM_WORDS; i++) begin
                is_enq = $urandom_range(99) < enq_bias;
                case ($urandom_range(3))
                    0:       prio = 16'($urandom_range(7));
                    1:       prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default: prio = 16'($urandom);
                endcase
                add_word(is_enq ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ, $urandom, prio,
                         (n % 100) == 99);
                n++;
            end
        end
        total_words = pending_words.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid || results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        $display("Run covered %0d words: %0d inserts, %0d removals,", words_sent,
                 n_inserted, n_removed);
        $display("%0d inserts refused as full, %0d removals refused as empty.",
                 n_full, n_empty);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
